>>> rtl/core/polar_point_distance_defines.svh
// assertion macros for the polar point distance block
`ifndef POLAR_POINT_DISTANCE_DEFINES_SVH
`define POLAR_POINT_DISTANCE_DEFINES_SVH

`ifndef SYNTHESIS
`define PPD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppd check failed");
`define PPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppd check failed");
`else
`define PPD_ASSERT_IMPL(label, ante, cons)
`define PPD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/core/ppd_pkg.sv
package ppd_pkg;

    localparam int RADIUS_BITS_DEF = 16;
    localparam int ANGLE_BITS_DEF  = 16;
    localparam int CORDIC_STEPS    = 30;
    localparam logic [31:0] COS_GAIN_INIT = 32'd163008218;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    // arctangent of 2^-i, 2^32 units per turn
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                5'd0:  v = 32'd536870912;
                5'd1:  v = 32'd316933406;
                5'd2:  v = 32'd167458907;
                5'd3:  v = 32'd85004756;
                5'd4:  v = 32'd42667331;
                5'd5:  v = 32'd21354465;
                5'd6:  v = 32'd10679838;
                5'd7:  v = 32'd5340245;
                5'd8:  v = 32'd2670163;
                5'd9:  v = 32'd1335087;
                5'd10: v = 32'd667544;
                5'd11: v = 32'd333772;
                5'd12: v = 32'd166886;
                5'd13: v = 32'd83443;
                5'd14: v = 32'd41722;
                5'd15: v = 32'd20861;
                5'd16: v = 32'd10430;
                5'd17: v = 32'd5215;
                5'd18: v = 32'd2608;
                5'd19: v = 32'd1304;
                5'd20: v = 32'd652;
                5'd21: v = 32'd326;
                5'd22: v = 32'd163;
                5'd23: v = 32'd81;
                5'd24: v = 32'd41;
                5'd25: v = 32'd20;
                5'd26: v = 32'd10;
                5'd27: v = 32'd5;
                5'd28: v = 32'd3;
                5'd29: v = 32'd1;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

endpackage

>>> rtl/core/ppd_cordic.sv
module ppd_cordic
    import ppd_pkg::*;
#(
    parameter int RADIUS_BITS = RADIUS_BITS_DEF,
    parameter int ANGLE_BITS  = ANGLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [RADIUS_BITS-1:0] radius,
    input  logic [ANGLE_BITS-1:0]  angle,
    output logic                   out_valid,
    output logic [RADIUS_BITS-1:0] out_radius,
    output logic signed [31:0]     cos_val,
    output logic signed [31:0]     sin_val
);

    logic [31:0] u_ang;
    logic [31:0] u_bias;
    quad_t       quad;
    logic [31:0] z_init;

    logic signed [31:0]     x_reg [CORDIC_STEPS+1];
    logic signed [31:0]     y_reg [CORDIC_STEPS+1];
    logic signed [31:0]     z_reg [CORDIC_STEPS+1];
    quad_t                  q_reg [CORDIC_STEPS+1];
    logic [RADIUS_BITS-1:0] r_reg [CORDIC_STEPS+1];
    logic                   v_reg [CORDIC_STEPS+1];

    logic signed [31:0]     cos_reg, cos_next;
    logic signed [31:0]     sin_reg, sin_next;
    logic [RADIUS_BITS-1:0] rad_reg;
    logic                   vout_reg;

    // split angle into quadrant and residual in [-pi/4, pi/4)
    always_comb
    begin
        u_ang  = 32'(angle) << (32 - ANGLE_BITS);
        u_bias = u_ang + 32'h2000_0000;
        quad   = quad_t'(u_bias[31:30]);
        z_init = u_ang - {u_bias[31:30], 30'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= signed'(COS_GAIN_INIT);
        y_reg[0] <= '0;
        z_reg[0] <= signed'(z_init);
        q_reg[0] <= quad;
        r_reg[0] <= radius;
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [31:0] xs;
        logic signed [31:0] ys;
        logic signed [31:0] x_next;
        logic signed [31:0] y_next;
        logic signed [31:0] z_next;

        always_comb
        begin
            xs = x_reg[i] >>> i;
            ys = y_reg[i] >>> i;
            if (z_reg[i][31])
            begin
                x_next = x_reg[i] + ys;
                y_next = y_reg[i] - xs;
                z_next = z_reg[i] + signed'(atan_turn(5'(i)));
            end
            else
            begin
                x_next = x_reg[i] - ys;
                y_next = y_reg[i] + xs;
                z_next = z_reg[i] - signed'(atan_turn(5'(i)));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i+1] <= x_next;
            y_reg[i+1] <= y_next;
            z_reg[i+1] <= z_next;
            q_reg[i+1] <= q_reg[i];
            r_reg[i+1] <= r_reg[i];
        end
    end

    // rotate result back into its quadrant
    always_comb
    begin
        case (q_reg[CORDIC_STEPS])
            QUAD_0:
            begin
                cos_next = x_reg[CORDIC_STEPS];
                sin_next = y_reg[CORDIC_STEPS];
            end
            QUAD_1:
            begin
                cos_next = -y_reg[CORDIC_STEPS];
                sin_next = x_reg[CORDIC_STEPS];
            end
            QUAD_2:
            begin
                cos_next = -x_reg[CORDIC_STEPS];
                sin_next = -y_reg[CORDIC_STEPS];
            end
            default:
            begin
                cos_next = y_reg[CORDIC_STEPS];
                sin_next = -x_reg[CORDIC_STEPS];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vout_reg <= 1'b0;
        end
        else
        begin
            vout_reg <= v_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        cos_reg <= cos_next;
        sin_reg <= sin_next;
        rad_reg <= r_reg[CORDIC_STEPS];
    end

    assign out_valid  = vout_reg;
    assign out_radius = rad_reg;
    assign cos_val    = cos_reg;
    assign sin_val    = sin_reg;

endmodule

>>> rtl/core/ppd_sqsum.sv
module ppd_sqsum
    import ppd_pkg::*;
#(
    parameter int RADIUS_BITS = RADIUS_BITS_DEF,
    localparam int MW = RADIUS_BITS + 31,
    localparam int NW = 2 * MW - 37
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [RADIUS_BITS-1:0] p_rad,
    input  logic signed [31:0]     p_cos,
    input  logic signed [31:0]     p_sin,
    input  logic [RADIUS_BITS-1:0] q_rad,
    input  logic signed [31:0]     q_cos,
    input  logic signed [31:0]     q_sin,
    output logic                   out_valid,
    output logic [NW-1:0]          radicand
);

    localparam int PW = RADIUS_BITS + 33;
    localparam int H  = (MW + 1) / 2;
    localparam int LW = MW - H;
    localparam int SW = 2 * MW + 1;

    logic signed [PW-1:0] xp_reg, yp_reg, xq_reg, yq_reg;
    logic signed [PW:0]   dx_s, dy_s, dx_a, dy_a;
    logic [MW-1:0]        dxm_reg, dym_reg;
    logic [2*LW-1:0]      dx_hh_reg, dy_hh_reg;
    logic [LW+H-1:0]      dx_hl_reg, dy_hl_reg;
    logic [2*H-1:0]       dx_ll_reg, dy_ll_reg;
    logic [SW-1:0]        sum_next;
    logic [NW-1:0]        rad_reg;
    logic [3:0]           v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    // coordinates, exact
    always_ff @(posedge clk)
    begin
        xp_reg <= $signed({1'b0, p_rad}) * p_cos;
        yp_reg <= $signed({1'b0, p_rad}) * p_sin;
        xq_reg <= $signed({1'b0, q_rad}) * q_cos;
        yq_reg <= $signed({1'b0, q_rad}) * q_sin;
    end

    always_comb
    begin
        dx_s = (PW+1)'(xq_reg) - (PW+1)'(xp_reg);
        dy_s = (PW+1)'(yq_reg) - (PW+1)'(yp_reg);
        dx_a = dx_s[PW] ? -dx_s : dx_s;
        dy_a = dy_s[PW] ? -dy_s : dy_s;
    end

    always_ff @(posedge clk)
    begin
        dxm_reg <= dx_a[MW-1:0];
        dym_reg <= dy_a[MW-1:0];
    end

    // squares as partial products of half words
    always_ff @(posedge clk)
    begin
        dx_hh_reg <= dxm_reg[MW-1:H] * dxm_reg[MW-1:H];
        dx_hl_reg <= dxm_reg[MW-1:H] * dxm_reg[H-1:0];
        dx_ll_reg <= dxm_reg[H-1:0] * dxm_reg[H-1:0];
        dy_hh_reg <= dym_reg[MW-1:H] * dym_reg[MW-1:H];
        dy_hl_reg <= dym_reg[MW-1:H] * dym_reg[H-1:0];
        dy_ll_reg <= dym_reg[H-1:0] * dym_reg[H-1:0];
    end

    always_comb
    begin
        sum_next = (SW'(dx_hh_reg) << (2 * H)) + (SW'(dx_hl_reg) << (H + 1))
                 + SW'(dx_ll_reg)
                 + (SW'(dy_hh_reg) << (2 * H)) + (SW'(dy_hl_reg) << (H + 1))
                 + SW'(dy_ll_reg);
    end

    // keep 18 fraction bits
    always_ff @(posedge clk)
    begin
        rad_reg <= sum_next[SW-1:38];
    end

    assign out_valid = v_reg[3];
    assign radicand  = rad_reg;

endmodule

>>> rtl/core/ppd_sqrt.sv
module ppd_sqrt
    import ppd_pkg::*;
#(
    parameter int NW = 2 * (RADIUS_BITS_DEF + 31) - 37,
    localparam int RT = (NW + 1) / 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] radicand,
    output logic          out_valid,
    output logic [RT-1:0] root
);

    localparam int NE = 2 * RT;
    localparam int RW = RT + 3;

    logic [RW-1:0] rem_reg  [RT+1];
    logic [RT-1:0] root_reg [RT+1];
    logic [NE-1:0] rad_reg  [RT+1];
    logic          v_reg    [RT+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
        rad_reg[0]  <= NE'(radicand);
    end

    // one root bit per stage, two radicand bits consumed
    for (genvar k = 0; k < RT; k++)
    begin : g_bit
        logic [RW-1:0] rem_w;
        logic [RW-1:0] trial;
        logic          fits;

        always_comb
        begin
            rem_w = {rem_reg[k][RW-3:0], rad_reg[k][NE-1:NE-2]};
            trial = {1'b0, root_reg[k], 2'b01};
            fits  = rem_w >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= fits ? rem_w - trial : rem_w;
            root_reg[k+1] <= {root_reg[k][RT-2:0], fits};
            rad_reg[k+1]  <= rad_reg[k] << 2;
        end
    end

    assign out_valid = v_reg[RT];
    assign root      = root_reg[RT];

endmodule

>>> rtl/core/polar_point_distance.sv
// polar point distance
// takes two points as radius and binary angle and returns the euclidean
// distance between them, unsigned with 8 fraction bits, rounded to nearest
// a word is taken at a clock edge with start high; busy stays low, so a
// new word may be given every cycle
// each result shows on distance for one cycle with done high
// the path is two 30-stage cordic pipelines with prep and quadrant stages,
// four stages of multiply and sum of squares, a load stage and one stage
// per root bit, and one output stage
// throughput is one word per cycle, set by the fully pipelined datapath
// reset clears the valid bits of every stage; words in flight are dropped
// there is no output stall: results cannot be held off
`include "polar_point_distance_defines.svh"
module polar_point_distance
    import ppd_pkg::*;
#(
    parameter int RADIUS_BITS = RADIUS_BITS_DEF,
    parameter int ANGLE_BITS  = ANGLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [RADIUS_BITS-1:0] p_radius,
    input  logic [ANGLE_BITS-1:0]  p_angle,
    input  logic [RADIUS_BITS-1:0] q_radius,
    input  logic [ANGLE_BITS-1:0]  q_angle,
    output logic                   done,
    output logic [RADIUS_BITS+8:0] distance
);

    localparam int MW = RADIUS_BITS + 31;
    localparam int NW = 2 * MW - 37;
    localparam int RT = (NW + 1) / 2;
    localparam int DW = RADIUS_BITS + 9;
    localparam logic [DW-1:0] DIST_MAX = {{RADIUS_BITS{1'b1}}, 9'd0};

    logic                   cp_valid, cq_valid;
    logic [RADIUS_BITS-1:0] cp_rad, cq_rad;
    logic signed [31:0]     cp_cos, cp_sin, cq_cos, cq_sin;
    logic                   sum_valid;
    logic [NW-1:0]          radicand;
    logic                   root_valid;
    logic [RT-1:0]          root;
    logic [RT-1:0]          rounded;
    logic [DW-1:0]          dist_next;
    logic [DW-1:0]          dist_reg;
    logic                   done_reg;

    assign busy = 1'b0;

    ppd_cordic #(
        .RADIUS_BITS (RADIUS_BITS),
        .ANGLE_BITS  (ANGLE_BITS)
    ) u_cordic_p (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start),
        .radius     (p_radius),
        .angle      (p_angle),
        .out_valid  (cp_valid),
        .out_radius (cp_rad),
        .cos_val    (cp_cos),
        .sin_val    (cp_sin)
    );

    ppd_cordic #(
        .RADIUS_BITS (RADIUS_BITS),
        .ANGLE_BITS  (ANGLE_BITS)
    ) u_cordic_q (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start),
        .radius     (q_radius),
        .angle      (q_angle),
        .out_valid  (cq_valid),
        .out_radius (cq_rad),
        .cos_val    (cq_cos),
        .sin_val    (cq_sin)
    );

    ppd_sqsum #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_sqsum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cp_valid),
        .p_rad     (cp_rad),
        .p_cos     (cp_cos),
        .p_sin     (cp_sin),
        .q_rad     (cq_rad),
        .q_cos     (cq_cos),
        .q_sin     (cq_sin),
        .out_valid (sum_valid),
        .radicand  (radicand)
    );

    ppd_sqrt #(
        .NW (NW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid),
        .radicand  (radicand),
        .out_valid (root_valid),
        .root      (root)
    );

    // round 9 fraction bits to 8, half up, then saturate
    always_comb
    begin
        rounded = (root >> 1) + RT'(root[0]);
        if (rounded > RT'(DIST_MAX))
        begin
            dist_next = DIST_MAX;
        end
        else
        begin
            dist_next = rounded[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= root_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
    end

    assign done     = done_reg;
    assign distance = dist_reg;

    `PPD_ASSERT_IMPL(lanes_aligned_a, 1'b1, cp_valid == cq_valid)
    `PPD_ASSERT_IMPL(dist_range_a, done, distance <= DIST_MAX)
    `PPD_ASSERT_NEXT(root_to_done_a, root_valid, done)

endmodule

>>> test/polar_point_distance_tb.sv
`timescale 1ns / 100ps

module polar_point_distance_tb;
    import ppd_pkg::*;

    localparam int RB = RADIUS_BITS_DEF;
    localparam int AB = ANGLE_BITS_DEF;
    localparam int LATENCY = RB + 51;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [RB-1:0] pr;
        logic [AB-1:0] pa;
        logic [RB-1:0] qr;
        logic [AB-1:0] qa;
    } point_pair_t;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    logic [RB-1:0] p_radius;
    logic [AB-1:0] p_angle;
    logic [RB-1:0] q_radius;
    logic [AB-1:0] q_angle;
    logic          done;
    logic [RB+8:0] distance;

    point_pair_t   pending_pairs[$];
    logic [RB+8:0] expected_dist[$];
    int            mismatches;
    int            idle_pct;
    logic          hold_off;
    logic          took_word;
    int            quiet_cycles;

    polar_point_distance dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .p_radius (p_radius),
        .p_angle  (p_angle),
        .q_radius (q_radius),
        .q_angle  (q_angle),
        .done     (done),
        .distance (distance)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // cosine and sine, 28 fraction bits, two's complement in 64 bits
    function automatic void cordic_sincos(input logic [AB-1:0] ang, output logic [63:0] c,
                                          output logic [63:0] s);
        logic [63:0] u;
        logic [63:0] z;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] xs;
        logic [63:0] ys;
        quad_t       quad;
        begin
            u = 64'(ang) << (32 - AB);
            quad = quad_t'(2'(((u + 64'h2000_0000) >> 30) & 64'd3));
            z = (u - (64'(quad) << 30)) & 64'hFFFF_FFFF;
            if (z[31])
                z = z | 64'hFFFF_FFFF_0000_0000;
            x = 64'(COS_GAIN_INIT);
            y = 64'd0;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                xs = 64'($signed(x) >>> i);
                ys = 64'($signed(y) >>> i);
                if (z[63])
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + 64'(atan_turn(5'(i)));
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - 64'(atan_turn(5'(i)));
                end
            end
            case (quad)
                QUAD_0: begin c = x;     s = y;     end
                QUAD_1: begin c = -y;    s = x;     end
                QUAD_2: begin c = -x;    s = -y;    end
                default: begin c = y;    s = -x;    end
            endcase
        end
    endfunction

    function automatic logic [RB+8:0] pair_distance(input point_pair_t w);
        logic [63:0]  pc;
        logic [63:0]  ps;
        logic [63:0]  qc;
        logic [63:0]  qs;
        logic [63:0]  dx;
        logic [63:0]  dy;
        logic [127:0] sum;
        logic [63:0]  root;
        logic [63:0]  cand;
        logic [63:0]  d;
        logic [63:0]  dmax;
        begin
            cordic_sincos(w.pa, pc, ps);
            cordic_sincos(w.qa, qc, qs);
            dx = 64'(w.qr) * qc - 64'(w.pr) * pc;
            dy = 64'(w.qr) * qs - 64'(w.pr) * ps;
            if (dx[63]) dx = -dx;
            if (dy[63]) dy = -dy;
            sum = {64'd0, dx} * {64'd0, dx} + {64'd0, dy} * {64'd0, dy};
            sum = sum >> 38;
            root = 64'd0;
            for (int b = 63; b >= 0; b--)
            begin
                cand = root | (64'd1 << b);
                if ({64'd0, cand} * {64'd0, cand} <= sum)
                    root = cand;
            end
            d = (root >> 1) + (root & 64'd1);
            dmax = ((64'd1 << RB) - 64'd1) * 64'd512;
            if (d > dmax)
                d = dmax;
            return d[RB+8:0];
        end
    endfunction

    task automatic report_mismatch(input string msg);
        begin
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        end
    endtask

    function automatic logic [15:0] pick_radius();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(0, 5))
            // near octant and quadrant boundaries
            0: return 16'({$urandom_range(0, 7), 13'd0} + $urandom_range(0, 2) - 1);
            1: return 16'({$urandom_range(0, 3), 14'd0});
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_pair(input logic [15:0] pr, input logic [15:0] pa,
                             input logic [15:0] qr, input logic [15:0] qa);
        point_pair_t w;
        begin
            w.pr = pr; w.pa = pa; w.qr = qr; w.qa = qa;
            pending_pairs.push_back(w);
        end
    endtask

    task automatic wait_drained();
        begin
            while (pending_pairs.size() != 0 || start || expected_dist.size() != 0)
                @(posedge clk);
        end
    endtask

    // driver: words change on the falling edge
    always @(negedge clk)
    begin
        if (!start || took_word)
        begin
            if (rst_n && !hold_off && pending_pairs.size() != 0
                && $urandom_range(0, 99) >= idle_pct)
            begin
                point_pair_t w;
                w = pending_pairs.pop_front();
                p_radius <= w.pr;
                p_angle  <= w.pa;
                q_radius <= w.qr;
                q_angle  <= w.qa;
                start    <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        logic accepted;
        point_pair_t w;
        logic [RB+8:0] exp_d;
        accepted = 1'b0;
        took_word <= start && !busy;
        if (rst_n && start && !busy)
        begin
            w.pr = p_radius; w.pa = p_angle; w.qr = q_radius; w.qa = q_angle;
            expected_dist.push_back(pair_distance(w));
            accepted = 1'b1;
        end
        if (rst_n && done)
        begin
            accepted = 1'b1;
            if (expected_dist.size() == 0)
                report_mismatch($sformatf("unexpected distance %0h", distance));
            else
            begin
                exp_d = expected_dist.pop_front();
                if (distance !== exp_d)
                    report_mismatch($sformatf("distance %0h, want %0h", distance, exp_d));
            end
        end
        if (accepted)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** polar_point_distance: FAILED **");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        p_radius = '0;
        p_angle = '0;
        q_radius = '0;
        q_angle = '0;
        mismatches = 0;
        idle_pct = 14;
        hold_off = 1'b0;
        took_word = 1'b0;
        quiet_cycles = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, coincident points, axes and boundaries
        push_pair(16'd0, 16'd0, 16'd0, 16'd0);
        push_pair(16'hFFFF, 16'd0, 16'hFFFF, 16'h8000);
        push_pair(16'hFFFF, 16'h4000, 16'hFFFF, 16'hC000);
        push_pair(16'hFFFF, 16'h2000, 16'hFFFF, 16'hA000);
        push_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
        push_pair(16'hFFFF, 16'h1FFF, 16'hFFFF, 16'h9FFF);
        push_pair(16'hFFFF, 16'h6000, 16'hFFFF, 16'hE000);
        push_pair(16'hFFFF, 16'h1234, 16'hFFFF, 16'h1234);
        push_pair(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_pair(16'hFFFF, 16'h5555, 16'h0000, 16'hAAAA);
        push_pair(16'd1, 16'd0, 16'd1, 16'h4000);
        push_pair(16'd1, 16'd0, 16'd1, 16'd1);
        push_pair(16'd1, 16'h2000, 16'd2, 16'h2001);
        push_pair(16'h8000, 16'hE000, 16'h7FFF, 16'h6000);
        push_pair(16'h5555, 16'hA000, 16'hAAAA, 16'h3FFF);
        push_pair(16'hAAAA, 16'h4001, 16'h5555, 16'hBFFF);
        push_pair(16'hFFFF, 16'hF000, 16'hFFFF, 16'h7000);
        push_pair(16'd3, 16'h8001, 16'd0, 16'd0);
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 14 : (phase == 1) ? 63 : 0;
            for (int n = 0; n < 230; n++)
            begin
                push_pair(pick_radius(), pick_angle(), pick_radius(), pick_angle());
                // sender holds off until the pipeline has emptied
                if (n == 115 && phase == 2)
                begin
                    while (pending_pairs.size() != 0)
                        @(posedge clk);
                    hold_off = 1'b1;
                    wait_drained();
                    hold_off = 1'b0;
                end
            end
            wait_drained();
        end

        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && expected_dist.size() == 0)
            $display("** polar_point_distance: PASSED **");
        else
            $display("** polar_point_distance: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/ppd_pkg.sv
rtl/core/ppd_cordic.sv
rtl/core/ppd_sqsum.sv
rtl/core/ppd_sqrt.sv
rtl/core/polar_point_distance.sv
test/polar_point_distance_tb.sv
